// ----- rtl/core/cdma_pkg.sv -----
// Shared types and constants for the DMA channel: item layouts, decoded
// operations, register offsets and control bits. No dependencies.
package cdma_pkg;

  // Input item modes
  typedef enum logic [1:0] {
    MODE_RD   = 2'd0,
    MODE_WR   = 2'd1,
    MODE_TICK = 2'd2
  } mode_e;

  // Decoded operation kinds handed from front to back
  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_TICK  = 2'd3
  } op_kind_e;

  // Memory request codes
  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } mem_req_e;

  // Register word offsets
  localparam logic [3:0] REG_RESET  = 4'd0;
  localparam logic [3:0] REG_CTRL   = 4'd1;
  localparam logic [3:0] REG_SRC    = 4'd2;
  localparam logic [3:0] REG_DST    = 4'd3;
  localparam logic [3:0] REG_LEN    = 4'd4;
  localparam logic [3:0] REG_STATUS = 4'd5;
  localparam logic [3:0] REG_ISR    = 4'd11;
  localparam logic [3:0] REG_IER    = 4'd12;

  // Control, status and interrupt bits
  localparam int CTRL_SRC_INC_BIT = 31;
  localparam int CTRL_DST_INC_BIT = 30;
  localparam logic [31:0] RESET_MAGIC = 32'h0000_000a;
  localparam int IRQ_ERR_BIT  = 1;
  localparam int IRQ_DONE_BIT = 0;
  localparam int IRQ_W        = 2;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  reg_offset;
    logic [31:0] write_value;
    logic [31:0] mem_read_value;
    logic        mem_fault;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  mem_request;
    logic [31:0] mem_address;
    logic [31:0] mem_write_value;
    logic [2:0]  mem_byte_count;
    logic        irq_line;
  } out_item_t;

  // Classified operation: register data or memory read data share one field
  typedef struct packed {
    op_kind_e    kind;
    logic [3:0]  offset;
    logic [31:0] value;
    logic        fault;
  } op_t;

endpackage

// ----- rtl/core/cdma_channel_if.sv -----
// Valid/ready channel interfaces for the DMA channel's input and result items.
// Depends on cdma_pkg for the item layouts.
interface cdma_in_if;
  import cdma_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cdma_out_if;
  import cdma_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/cdma_front.sv -----
// Front end of the DMA channel: classifies incoming items and queues them
// for the back end. Depends on cdma_pkg and cdma_in_if.
module cdma_front (
  input  logic           clk,
  input  logic           rst_n,
  cdma_in_if.sink        in_ch,
  output logic           q_valid,
  output cdma_pkg::op_t  q_head,
  input  logic           q_pop
);
  import cdma_pkg::*;

  op_t               op_new;
  logic              push;
  op_t               q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // Classify the item by mode
  always_comb begin
    op_new.offset = in_ch.data.reg_offset;
    op_new.fault  = in_ch.data.mem_fault;
    op_new.value  = in_ch.data.mem_read_value;
    case (in_ch.data.mode)
      MODE_RD: begin
        op_new.kind = OP_READ;
      end
      MODE_WR: begin
        op_new.kind  = OP_WRITE;
        op_new.value = in_ch.data.write_value;
      end
      MODE_TICK: begin
        op_new.kind = OP_TICK;
      end
      default: begin
        op_new.kind = OP_NOP;
      end
    endcase
  end

  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_head      = q_mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_new;
    end
  end

endmodule

// ----- rtl/core/cdma_back.sv -----
// Back end of the DMA channel: holds the channel registers, executes one
// queued operation per cycle unless the held result is stalled, and registers the result item.
// Depends on cdma_pkg and cdma_out_if.
module cdma_back #(
  parameter int ADDR_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  cdma_pkg::op_t  q_head,
  output logic           q_pop,
  cdma_out_if.source     out_ch
);
  import cdma_pkg::*;

  localparam int PW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  logic [31:0]      ctrl_r, ctrl_nxt;
  logic [PW-1:0]    src_r, src_nxt;
  logic [PW-1:0]    dst_r, dst_nxt;
  logic [31:0]      len_r, len_nxt;
  logic             busy_r, busy_nxt;
  logic             fault_r, fault_nxt;
  logic [IRQ_W-1:0] isr_r, isr_nxt;
  logic [IRQ_W-1:0] ier_r, ier_nxt;
  logic             phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        res;
  logic [2:0]       chunk;
  logic             exec;

  assign exec  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = exec;

  // Bytes per memory access: single byte when both sides increment, else the remaining length capped at four
  always_comb begin
    if (ctrl_r[CTRL_SRC_INC_BIT] && ctrl_r[CTRL_DST_INC_BIT]) begin
      chunk = 3'd1;
    end else if (len_r < 32'd4) begin
      chunk = len_r[2:0];
    end else begin
      chunk = 3'd4;
    end
  end

  // Execute the head operation
  always_comb begin
    ctrl_nxt  = ctrl_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    len_nxt   = len_r;
    busy_nxt  = busy_r;
    fault_nxt = fault_r;
    isr_nxt   = isr_r;
    ier_nxt   = ier_r;
    phase_nxt = phase_r;
    res       = '0;
    case (q_head.kind)
      OP_READ: begin
        case (q_head.offset)
          REG_CTRL:   res.read_value = ctrl_r;
          REG_SRC:    res.read_value = 32'(src_r);
          REG_DST:    res.read_value = 32'(dst_r);
          REG_LEN:    res.read_value = len_r;
          REG_STATUS: res.read_value = {busy_r, fault_r, 30'd0};
          REG_ISR:    res.read_value = 32'(isr_r);
          REG_IER:    res.read_value = 32'(ier_r);
          default:    res.read_value = '0;
        endcase
      end
      OP_WRITE: begin
        case (q_head.offset)
          REG_RESET: begin
            if (q_head.value == RESET_MAGIC) begin
              ctrl_nxt  = '0;
              src_nxt   = '0;
              dst_nxt   = '0;
              len_nxt   = '0;
              busy_nxt  = 1'b0;
              fault_nxt = 1'b0;
              isr_nxt   = '0;
              ier_nxt   = '0;
              phase_nxt = 1'b0;
            end
          end
          REG_CTRL: begin
            if (!busy_r) ctrl_nxt = q_head.value;
          end
          REG_SRC: begin
            if (!busy_r) src_nxt = q_head.value[PW-1:0];
          end
          REG_DST: begin
            if (!busy_r) dst_nxt = q_head.value[PW-1:0];
          end
          REG_LEN: begin
            if (!busy_r) begin
              len_nxt = q_head.value;
              if (q_head.value != '0) begin
                busy_nxt  = 1'b1;
                phase_nxt = 1'b0;
              end
            end
          end
          REG_ISR: begin
            isr_nxt = isr_r ^ q_head.value[IRQ_W-1:0];
          end
          REG_IER: begin
            ier_nxt = q_head.value[IRQ_W-1:0];
          end
          default: begin
          end
        endcase
      end
      OP_TICK: begin
        if (busy_r) begin
          if (!phase_r) begin
            // read phase: fetch from source
            res.mem_request    = REQ_READ;
            res.mem_address    = 32'(src_r);
            res.mem_byte_count = chunk;
            phase_nxt          = 1'b1;
          end else if (q_head.fault) begin
            // read failed: flag and stop
            fault_nxt            = 1'b1;
            isr_nxt[IRQ_ERR_BIT] = 1'b1;
            busy_nxt             = 1'b0;
            phase_nxt            = 1'b0;
          end else begin
            // write phase: store returned data to destination
            res.mem_request    = REQ_WRITE;
            res.mem_address    = 32'(dst_r);
            res.mem_byte_count = chunk;
            case (chunk)
              3'd1:    res.mem_write_value = {24'd0, q_head.value[7:0]};
              3'd2:    res.mem_write_value = {16'd0, q_head.value[15:0]};
              3'd3:    res.mem_write_value = {8'd0, q_head.value[23:0]};
              default: res.mem_write_value = q_head.value;
            endcase
            if (ctrl_r[CTRL_SRC_INC_BIT]) src_nxt = src_r + PW'(chunk);
            if (ctrl_r[CTRL_DST_INC_BIT]) dst_nxt = dst_r + PW'(chunk);
            len_nxt   = len_r - 32'(chunk);
            phase_nxt = 1'b0;
            if (len_nxt == '0) begin
              busy_nxt              = 1'b0;
              isr_nxt[IRQ_DONE_BIT] = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.irq_line = |(isr_nxt & ier_nxt);
  end

  // Hold the result until taken
  assign out_valid_nxt = exec ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      len_r       <= '0;
      busy_r      <= 1'b0;
      fault_r     <= 1'b0;
      isr_r       <= '0;
      ier_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        ctrl_r  <= ctrl_nxt;
        src_r   <= src_nxt;
        dst_r   <= dst_nxt;
        len_r   <= len_nxt;
        busy_r  <= busy_nxt;
        fault_r <= fault_nxt;
        isr_r   <= isr_nxt;
        ier_r   <= ier_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (exec) begin
      out_data_r <= res;
    end
  end

endmodule

// ----- rtl/core/central_dma_channel.sv -----
// Top level of one DMA channel: front end with item queue, back end with
// channel registers and result register. Depends on cdma_pkg, the channel
// interfaces, cdma_front and cdma_back.
//
//   channel | direction | payload                                   | handshake
//   in_ch   | sink      | mode, reg_offset, write_value,            | valid/ready
//           |           | mem_read_value, mem_fault                 |
//   out_ch  | source    | read_value, mem_request, mem_address,     | valid/ready
//           |           | mem_write_value, mem_byte_count, irq_line |
//
// One item per cycle sustained while out_ch.ready stays high; an accepted item
// waits in the queue until the back end executes it at the queue head, and its
// result is then held in the result register until out_ch takes it.
// Synchronous active-low reset empties the queue and clears all channel
// registers and the pending result.
// A stalled result holds in the output register; the queue absorbs two more
// items before in_ch.ready drops.
module central_dma_channel #(
  parameter int ADDR_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cdma_in_if.sink    in_ch,
  cdma_out_if.source out_ch
);
  import cdma_pkg::*;

  logic q_valid;
  op_t  q_head;
  logic q_pop;

  cdma_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  cdma_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // Back end pops only a present item
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Back end never overwrites a result that is still held
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten while stalled");

  // An accepted item is queued on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> q_valid)
    else $error("accepted item missing from queue");

  // A new result follows an execution
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(q_pop))
    else $error("result appeared without execution");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for central_dma_channel: directed and random register,
// engine-tick and fault traffic checked against an in-bench channel predictor.
// Depends on cdma_pkg, the channel interfaces and the central_dma_channel RTL.
module testbench;
  import cdma_pkg::*;

  localparam int ADDR_BITS = 32;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int ITEM_TARGET = 700;
  localparam int MAX_TICKS = 48;
  localparam int REPORT_LIMIT = 10;
  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hffff_ffff : ((32'h1 << ADDR_BITS) - 32'h1);
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [3:0] REG_SPARE_LO = 4'd7;
  localparam logic [3:0] REG_SPARE_HI = 4'd15;
  localparam logic [31:0] SRC_INC = 32'h1 << CTRL_SRC_INC_BIT;
  localparam logic [31:0] DST_INC = 32'h1 << CTRL_DST_INC_BIT;

  logic clk = 1'b0;
  logic rst_n;

  cdma_in_if  in_ch ();
  cdma_out_if out_ch ();

  central_dma_channel #(.ADDR_BITS(ADDR_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Predicted channel state
  logic [31:0]      ch_ctrl, ch_src, ch_dst, ch_len, ch_held;
  logic             ch_busy, ch_fault, ch_wphase;
  logic [IRQ_W-1:0] ch_isr, ch_ier;

  out_item_t pending_results[$];
  out_item_t want_result;
  int        mismatches = 0;
  int        items_done = 0;
  int        stall_cycles = 0;
  int        hold_left = 0;
  bit        hold_req = 1'b0;
  bit        steady = 1'b0;

  // ---------------------------------------------------------------------------
  // Channel predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_channel();
    ch_ctrl = '0;
    ch_src = '0;
    ch_dst = '0;
    ch_len = '0;
    ch_held = '0;
    ch_busy = 1'b0;
    ch_fault = 1'b0;
    ch_wphase = 1'b0;
    ch_isr = '0;
    ch_ier = '0;
  endfunction

  function automatic logic [31:0] chunk_bytes();
    if (ch_ctrl[CTRL_SRC_INC_BIT] && ch_ctrl[CTRL_DST_INC_BIT]) return 32'd1;
    return (ch_len < 32'd4) ? ch_len : 32'd4;
  endfunction

  function automatic logic [31:0] reg_contents(logic [3:0] off);
    case (off)
      REG_CTRL:   return ch_ctrl;
      REG_SRC:    return ch_src;
      REG_DST:    return ch_dst;
      REG_LEN:    return ch_len;
      REG_STATUS: return {ch_busy, ch_fault, 30'd0};
      REG_ISR:    return {{(32-IRQ_W){1'b0}}, ch_isr};
      REG_IER:    return {{(32-IRQ_W){1'b0}}, ch_ier};
      default:    return 32'd0;
    endcase
  endfunction

  function automatic void apply_reg_write(logic [3:0] off, logic [31:0] v);
    case (off)
      REG_RESET: if (v == RESET_MAGIC) clear_channel();
      REG_CTRL:  if (!ch_busy) ch_ctrl = v;
      REG_SRC:   if (!ch_busy) ch_src = v & ADDR_MASK;
      REG_DST:   if (!ch_busy) ch_dst = v & ADDR_MASK;
      REG_LEN: begin
        if (!ch_busy) begin
          ch_len = v;
          if (v != 32'd0) begin
            ch_busy = 1'b1;
            ch_wphase = 1'b0;
          end
        end
      end
      REG_ISR:   ch_isr = ch_isr ^ v[IRQ_W-1:0];
      REG_IER:   ch_ier = v[IRQ_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic out_item_t dma_channel_step(in_item_t it);
    out_item_t   res;
    logic [31:0] cnt;
    logic [63:0] keep;
    res = '0;
    case (it.mode)
      MODE_RD: res.read_value = reg_contents(it.reg_offset);
      MODE_WR: apply_reg_write(it.reg_offset, it.write_value);
      MODE_TICK: begin
        if (ch_busy) begin
          if (!ch_wphase) begin
            // read phase: fetch from the source
            cnt = chunk_bytes();
            res.mem_request = REQ_READ;
            res.mem_address = ch_src;
            res.mem_byte_count = cnt[2:0];
            ch_wphase = 1'b1;
          end else if (it.mem_fault) begin
            // failed read: flag the error and stop
            ch_fault = 1'b1;
            ch_isr[IRQ_ERR_BIT] = 1'b1;
            ch_busy = 1'b0;
            ch_wphase = 1'b0;
          end else begin
            // write phase: store the returned data and advance
            cnt = chunk_bytes();
            ch_held = it.mem_read_value;
            keep = (64'd1 << (cnt * 8)) - 64'd1;
            res.mem_request = REQ_WRITE;
            res.mem_address = ch_dst;
            res.mem_byte_count = cnt[2:0];
            res.mem_write_value = (cnt >= 32'd4) ? ch_held : (ch_held & keep[31:0]);
            if (ch_ctrl[CTRL_SRC_INC_BIT]) ch_src = (ch_src + cnt) & ADDR_MASK;
            if (ch_ctrl[CTRL_DST_INC_BIT]) ch_dst = (ch_dst + cnt) & ADDR_MASK;
            ch_len = ch_len - cnt;
            ch_wphase = 1'b0;
            if (ch_len == 32'd0) begin
              ch_busy = 1'b0;
              ch_isr[IRQ_DONE_BIT] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res.irq_line = |(ch_isr & ch_ier);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [1:0] mode, logic [3:0] off, logic [31:0] wval,
                           logic [31:0] rdata, logic fault);
    in_item_t it;
    it.mode = mode;
    it.reg_offset = off;
    it.write_value = wval;
    it.mem_read_value = rdata;
    it.mem_fault = fault;
    // idle for a random number of cycles
    if (!steady) begin
      while ($urandom_range(99) < 25) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    // ignored items do not count toward the target
    if (mode != MODE_UNUSED && !(mode == MODE_TICK && !ch_busy)) items_done++;
    pending_results.push_back(dma_channel_step(it));
  endtask

  task automatic reg_write(logic [3:0] off, logic [31:0] v);
    send_item(MODE_WR, off, v, $urandom(), 1'($urandom_range(1)));
  endtask

  task automatic reg_read(logic [3:0] off);
    send_item(MODE_RD, off, $urandom(), $urandom(), 1'($urandom_range(1)));
  endtask

  task automatic engine_tick(logic [31:0] rdata, logic fault);
    send_item(MODE_TICK, 4'($urandom_range(15)), $urandom(), rdata, fault);
  endtask

  function automatic logic [31:0] wrap_prone_addr();
    if ($urandom_range(3) == 0) return 32'hffff_fff0 | 32'($urandom_range(15));
    return $urandom();
  endfunction

  // Random item of any kind, now and then the reset magic
  task automatic send_noise();
    logic [31:0] wval;
    wval = ($urandom_range(15) == 0) ? RESET_MAGIC : $urandom();
    send_item(2'($urandom_range(3)), 4'($urandom_range(15)), wval, $urandom(),
              1'($urandom_range(1)));
  endtask

  // Program one transfer with random content and run it until it ends or is aborted
  task automatic run_transfer();
    logic [31:0] len;
    int          ticks;
    if ($urandom_range(19) == 0) reg_write(REG_RESET, RESET_MAGIC);
    reg_write(REG_CTRL, $urandom());
    reg_write(REG_SRC, wrap_prone_addr());
    reg_write(REG_DST, wrap_prone_addr());
    if ($urandom_range(3) == 0) reg_write(REG_IER, $urandom());
    case ($urandom_range(19))
      0:       len = 32'd0;
      1:       len = $urandom();
      default: len = 32'($urandom_range(1, 12));
    endcase
    reg_write(REG_LEN, len);
    ticks = 0;
    while (ch_busy && ticks < MAX_TICKS) begin
      if ($urandom_range(99) < 15) send_noise();
      engine_tick($urandom(), ch_wphase ? 1'($urandom_range(99) < 4)
                                        : 1'($urandom_range(1)));
      ticks++;
    end
    // abort anything too long to finish
    if (ch_busy) reg_write(REG_RESET, RESET_MAGIC);
    repeat ($urandom_range(1, 3)) reg_read(4'($urandom_range(15)));
    if ($urandom_range(2) == 0) reg_write(REG_ISR, $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_register_access();
    reg_write(REG_IER, 32'hffff_ffff);
    reg_write(REG_ISR, 32'hffff_ffff);
    reg_write(REG_ISR, 32'h0000_0003);
    reg_write(REG_CTRL, 32'hffff_ffff);
    reg_write(REG_SRC, 32'hffff_ffff);
    reg_write(REG_DST, 32'hffff_fffe);
    reg_read(REG_RESET);
  endtask

  // Single byte with both increments, source wraps past the top
  task automatic test_byte_transfer();
    reg_write(REG_LEN, 32'd1);
    reg_write(REG_CTRL, 32'd0);
    engine_tick(32'hffff_ffff, 1'b0);
    engine_tick(32'hffff_ffff, 1'b0);
    engine_tick(32'hffff_ffff, 1'b0);
  endtask

  // Four bytes, then a two-byte remainder
  task automatic test_keyhole_transfer();
    reg_write(REG_CTRL, SRC_INC);
    reg_write(REG_LEN, 32'd6);
    engine_tick(32'h0, 1'b0);
    engine_tick(32'hdead_beef, 1'b0);
    engine_tick(32'h0, 1'b0);
    engine_tick(32'hcafe_f00d, 1'b0);
  endtask

  task automatic test_ignored_writes();
    reg_write(REG_LEN, 32'd0);
    reg_write(REG_STATUS, 32'hffff_ffff);
    reg_write(REG_SPARE_LO, 32'hffff_ffff);
    send_item(MODE_UNUSED, REG_CTRL, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
  endtask

  task automatic test_bus_fault();
    reg_write(REG_LEN, 32'd3);
    engine_tick(32'h1234_5678, 1'b0);
    engine_tick(32'h1234_5678, 1'b1);
    reg_read(REG_STATUS);
  endtask

  task automatic test_reset_register();
    reg_write(REG_RESET, RESET_MAGIC ^ 32'h1);
    reg_write(REG_RESET, RESET_MAGIC);
  endtask

  // Stall the result side while items keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    reg_write(REG_CTRL, DST_INC | DST_INC >> 2);
    reg_write(REG_LEN, 32'd8);
    repeat (24) begin
      if (ch_busy) engine_tick($urandom(), 1'b0);
      else reg_read(REG_SPARE_HI);
    end
  endtask

  task automatic test_no_idle_stretch();
    int start;
    start = items_done;
    steady = 1'b1;
    while (items_done < start + 120) run_transfer();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    while (items_done < ITEM_TARGET) run_transfer();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern with one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result item: %h", out_ch.data);
      end else begin
        want_result = pending_results.pop_front();
        check_field("read_value", want_result.read_value, out_ch.data.read_value);
        check_field("mem_request", 32'(want_result.mem_request),
                    32'(out_ch.data.mem_request));
        check_field("mem_address", want_result.mem_address, out_ch.data.mem_address);
        check_field("mem_write_value", want_result.mem_write_value,
                    out_ch.data.mem_write_value);
        check_field("mem_byte_count", 32'(want_result.mem_byte_count),
                    32'(out_ch.data.mem_byte_count));
        check_field("irq_line", 32'(want_result.irq_line), 32'(out_ch.data.irq_line));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_channel();
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_byte_transfer();
    test_keyhole_transfer();
    test_ignored_writes();
    test_bus_fault();
    test_reset_register();
    test_backpressure();
    test_no_idle_stretch();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/cdma_pkg.sv
rtl/core/cdma_channel_if.sv
rtl/core/cdma_front.sv
rtl/core/cdma_back.sv
rtl/core/central_dma_channel.sv
test/testbench.sv
